[sv/sab_pkg.sv]
// ----------------------------------------------------------------------------
// sab_pkg
// Shared types and constants of the suffix array builder.
// ----------------------------------------------------------------------------
package sab_pkg;

    localparam int MAX_LEN = 64;
    localparam int NCELLS  = MAX_LEN + 1;           // text plus sentinel
    localparam int LEN_W   = $clog2(MAX_LEN + 1);   // holds 0..MAX_LEN
    localparam int ADDR_W  = $clog2(MAX_LEN);       // text store address
    localparam int POS_W   = $clog2(NCELLS);        // position 0..MAX_LEN
    localparam int CNT_W   = $clog2(NCELLS + 1);    // holds 0..NCELLS
    localparam int RANK_W  = 7;
    localparam int KEY_W   = 2 * RANK_W;
    localparam int OFF_W   = CNT_W + 1;             // offset may reach 2*N

    // one entry of the sorting chain
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [POS_W-1:0]  pos;
    } item_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT
    } chain_op_t;

    // control word broadcast to every cell
    typedef struct packed {
        chain_op_t op;
        item_t     new_item;
    } chain_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_FLUSH,
        ST_DRAIN,
        ST_EMIT
    } state_t;

endpackage

[sv/sab_cell.sv]
// ----------------------------------------------------------------------------
// sab_cell
// One cell of the insertion chain: holds one (key, position) entry.
// ----------------------------------------------------------------------------
module sab_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  sab_pkg::chain_ctl_t ctl,
    input  sab_pkg::item_t     left,
    input  sab_pkg::item_t     right,
    output sab_pkg::item_t     item
);
    import sab_pkg::*;

    logic              valid_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [POS_W-1:0]  pos_reg;
    item_t             item_next;
    logic              gt_self;
    logic              gt_left;

    assign item = '{valid: valid_reg, key: key_reg, pos: pos_reg};

    // an empty slot counts as greater than any key; equal keys stay ahead
    always_comb
    begin
        gt_self   = !item.valid || (item.key > ctl.new_item.key);
        gt_left   = !left.valid || (left.key > ctl.new_item.key);
        item_next = item;
        unique case (ctl.op)
            OP_HOLD:
            begin
                item_next = item;
            end
            OP_INSERT:
            begin
                if (gt_self)
                begin
                    item_next = gt_left ? left : ctl.new_item;
                end
            end
            OP_SHIFT:
            begin
                item_next = right;
            end
            default:
            begin
                item_next = item;
            end
        endcase
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= item_next.valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        key_reg <= item_next.key;
        pos_reg <= item_next.pos;
    end

endmodule

[sv/sab_chain.sv]
// ----------------------------------------------------------------------------
// sab_chain
// Row of sorting cells: ascending insertion sort, drained from the head.
// ----------------------------------------------------------------------------
module sab_chain (
    input  logic                clk,
    input  logic                rst_n,
    input  sab_pkg::chain_ctl_t ctl,
    output sab_pkg::item_t      head
);
    import sab_pkg::*;

    item_t items [NCELLS];
    item_t lefts [NCELLS];
    item_t rights[NCELLS];

    // neighbor wiring; the head sees a minimal left, the tail an empty right
    always_comb
    begin
        for (int i = 0; i < NCELLS; i++)
        begin
            if (i == 0)
            begin
                lefts[i] = '{valid: 1'b1, key: '0, pos: '0};
            end
            else
            begin
                lefts[i] = items[i-1];
            end
            if (i == NCELLS - 1)
            begin
                rights[i] = '{valid: 1'b0, key: '0, pos: '0};
            end
            else
            begin
                rights[i] = items[i+1];
            end
        end
    end

    for (genvar g = 0; g < NCELLS; g++)
    begin : g_cell
        sab_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .left  (lefts[g]),
            .right (rights[g]),
            .item  (items[g])
        );
    end

    assign head = items[0];

endmodule

[sv/suffix_array_builder_unit.sv]
// ----------------------------------------------------------------------------
// suffix_array_builder_unit
// Builds the suffix array of a byte text by prefix doubling.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries the text, one byte per transfer, tlast on the final
//   byte. Bytes past 64 are dropped and flagged. After the final byte the
//   block stops taking input and builds the array in a chain of 65 sorting
//   cells; rank tables live in a small two-read-port memory.
//   Master stream then gives one transfer per stored byte: the suffix start
//   positions in sorted order, tlast on the last one, tuser set if the text
//   overflowed.
//   Loading takes one byte per cycle. Each sort round fills the chain and
//   then drains it; for N = length + 1 there are 1 + ceil(log2 N) rounds,
//   the last of which drains straight to the output. The chain fill and
//   drain set the throughput: the next text is taken only after the last
//   output transfer.
//   Reset empties the chain and clears length and overflow state.
//   A stalled receiver holds the chain; nothing is lost.
// ----------------------------------------------------------------------------
module suffix_array_builder_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_value
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [5:0] suffix_start, [7:6] zero
    output logic       m_tlast,
    output logic       m_tuser    // [0] overflow
);
    import sab_pkg::*;

    state_t            state_reg,    state_next;
    logic [LEN_W-1:0]  len_reg,      len_next;
    logic              ovf_reg,      ovf_next;
    logic [CNT_W-1:0]  n_reg,        n_next;
    logic [CNT_W-1:0]  idx_reg,      idx_next;
    logic [POS_W-1:0]  k_reg,        k_next;
    logic [OFF_W-1:0]  off_reg,      off_next;
    logic              round0_reg,   round0_next;
    logic              final_reg,    final_next;
    logic [RANK_W-1:0] cls_reg,      cls_next;
    logic [KEY_W-1:0]  prev_key_reg, prev_key_next;
    logic              ins_valid_reg, ins_valid_next;
    logic [POS_W-1:0]  ins_pos_reg,  ins_pos_next;
    logic              ins_sent_reg, ins_sent_next;

    logic [7:0]        text_mem [MAX_LEN];
    logic [RANK_W-1:0] rank_mem [NCELLS];
    logic [7:0]        text_rd;
    logic [RANK_W-1:0] rank_rd_a;
    logic [RANK_W-1:0] rank_rd_b;

    logic              text_we;
    logic              rank_we;
    logic [POS_W-1:0]  rank_wa;
    logic [RANK_W-1:0] rank_wd;
    logic              rd_en;

    chain_ctl_t        ctl;
    chain_op_t         chain_op;
    item_t             ins_item;
    item_t             head;
    logic              s_xfer;
    logic              m_xfer;

    assign s_xfer = s_tvalid && s_tready;
    assign m_xfer = m_tvalid && m_tready;

    // text store
    always_ff @(posedge clk)
    begin
        if (text_we)
        begin
            text_mem[len_reg[ADDR_W-1:0]] <= s_tdata;
        end
        if (rd_en)
        begin
            text_rd <= text_mem[idx_reg[ADDR_W-1:0]];
        end
    end

    // class rank store: one write, two reads
    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_mem[rank_wa] <= rank_wd;
        end
        if (rd_en)
        begin
            rank_rd_a <= rank_mem[idx_reg[POS_W-1:0]];
            rank_rd_b <= rank_mem[k_reg];
        end
    end

    // insertion key from registered memory data
    always_comb
    begin
        ins_item.valid = 1'b1;
        ins_item.pos   = ins_pos_reg;
        if (!round0_reg)
        begin
            ins_item.key = {rank_rd_a, rank_rd_b};
        end
        else if (ins_sent_reg)
        begin
            ins_item.key = '0;
        end
        else
        begin
            ins_item.key = KEY_W'({1'b0, text_rd} + 9'd1);
        end
    end

    assign ctl = '{op: chain_op, new_item: ins_item};

    sab_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .head  (head)
    );

    // outputs
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT) && (idx_reg != '0);
    assign m_tdata  = {2'b00, head.pos[5:0]};
    assign m_tlast  = (idx_reg == n_reg - CNT_W'(1));
    assign m_tuser  = ovf_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        off_next       = off_reg;
        round0_next    = round0_reg;
        final_next     = final_reg;
        cls_next       = cls_reg;
        prev_key_next  = prev_key_reg;
        ins_valid_next = 1'b0;
        ins_pos_next   = ins_pos_reg;
        ins_sent_next  = ins_sent_reg;
        text_we        = 1'b0;
        rank_we        = 1'b0;
        rank_wa        = head.pos;
        rank_wd        = cls_reg;
        rd_en          = 1'b0;
        chain_op       = ins_valid_reg ? OP_INSERT : OP_HOLD;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    if (len_reg < LEN_W'(MAX_LEN))
                    begin
                        text_we  = 1'b1;
                        len_next = len_reg + LEN_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        n_next      = CNT_W'(len_next) + CNT_W'(1);
                        idx_next    = '0;
                        round0_next = 1'b1;
                        off_next    = OFF_W'(1);
                        state_next  = ST_FILL;
                    end
                end
            end
            ST_FILL:
            begin
                // issue reads for position idx, insert in the cycle after
                rd_en          = 1'b1;
                ins_valid_next = 1'b1;
                ins_pos_next   = idx_reg[POS_W-1:0];
                ins_sent_next  = (idx_reg == CNT_W'(len_reg));
                idx_next       = idx_reg + CNT_W'(1);
                if (k_reg == POS_W'(n_reg - CNT_W'(1)))
                begin
                    k_next = '0;
                end
                else
                begin
                    k_next = k_reg + POS_W'(1);
                end
                if (idx_reg == n_reg - CNT_W'(1))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                idx_next   = '0;
                final_next = (off_reg >= OFF_W'(n_reg));
                state_next = (off_reg >= OFF_W'(n_reg)) ? ST_EMIT : ST_DRAIN;
            end
            ST_DRAIN:
            begin
                // dense class ranks as the sorted order leaves the head
                chain_op = OP_SHIFT;
                if (idx_reg == '0)
                begin
                    cls_next = '0;
                end
                else if (head.key != prev_key_reg)
                begin
                    cls_next = cls_reg + RANK_W'(1);
                end
                rank_we       = 1'b1;
                rank_wd       = cls_next;
                prev_key_next = head.key;
                idx_next      = idx_reg + CNT_W'(1);
                if (idx_reg == n_reg - CNT_W'(1))
                begin
                    idx_next    = '0;
                    round0_next = 1'b0;
                    k_next      = off_reg[POS_W-1:0];
                    off_next    = off_reg << 1;
                    state_next  = ST_FILL;
                end
            end
            ST_EMIT:
            begin
                // head entry zero is the sentinel and is dropped
                if ((idx_reg == '0) || m_tready)
                begin
                    chain_op = OP_SHIFT;
                    idx_next = idx_reg + CNT_W'(1);
                    if (idx_reg == n_reg - CNT_W'(1))
                    begin
                        len_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    chain_op = OP_HOLD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            ins_valid_reg <= 1'b0;
            n_reg         <= '0;
            idx_reg       <= '0;
            k_reg         <= '0;
            off_reg       <= '0;
            round0_reg    <= 1'b0;
            final_reg     <= 1'b0;
            cls_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            ins_valid_reg <= ins_valid_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            k_reg         <= k_next;
            off_reg       <= off_next;
            round0_reg    <= round0_next;
            final_reg     <= final_next;
            cls_reg       <= cls_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prev_key_reg <= prev_key_next;
        ins_pos_reg  <= ins_pos_next;
        ins_sent_reg <= ins_sent_next;
    end

`ifndef SYNTHESIS
    // a result is only offered from a filled chain head
    a_emit_head: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> head.valid)
        else $error("emit from empty chain head");

    // the drain always sees a filled head
    a_drain_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> head.valid)
        else $error("drain from empty chain head");

    // fill stays inside the current text
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (idx_reg < n_reg))
        else $error("fill index out of range");

    // final transfer closes the text
    a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (m_xfer && m_tlast) |=> ((len_reg == '0) && !ovf_reg && s_tready))
        else $error("state not cleared after final transfer");

    // emission only happens in the round flagged final
    a_emit_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> final_reg)
        else $error("emit outside final round");
`endif

endmodule
